// ===== rtl/dct_pkg.sv =====
package dct_pkg;

   localparam int LENGTH   = 8;
   localparam int IDX_W    = $clog2(LENGTH);
   localparam int BUF_AW   = IDX_W + 1;
   localparam int ROM_AW   = 2 * IDX_W;
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 20;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int ACC_W    = PROD_W + IDX_W + 1;
   localparam int FRAC_SH  = 15;
   localparam int Q_W      = ACC_W - FRAC_SH;
   localparam int COEF_MAX = (1 <<< (COEF_W - 1)) - 1;
   localparam int COEF_MIN = -(1 <<< (COEF_W - 1));

   localparam logic MODE_FWD = 1'b0;
   localparam logic MODE_INV = 1'b1;

   // Orthonormal DCT-II weights, Q1.15, row k (frequency) by column n (sample)
   localparam logic signed [SAMPLE_W-1:0] ROM [0:LENGTH*LENGTH-1] = '{
      16'sd11585,  16'sd11585,  16'sd11585,  16'sd11585,
      16'sd11585,  16'sd11585,  16'sd11585,  16'sd11585,
      16'sd16069,  16'sd13623,  16'sd9102,   16'sd3196,
      -16'sd3196,  -16'sd9102,  -16'sd13623, -16'sd16069,
      16'sd15137,  16'sd6270,   -16'sd6270,  -16'sd15137,
      -16'sd15137, -16'sd6270,  16'sd6270,   16'sd15137,
      16'sd13623,  -16'sd3196,  -16'sd16069, -16'sd9102,
      16'sd9102,   16'sd16069,  16'sd3196,   -16'sd13623,
      16'sd11585,  -16'sd11585, -16'sd11585, 16'sd11585,
      16'sd11585,  -16'sd11585, -16'sd11585, 16'sd11585,
      16'sd9102,   -16'sd16069, 16'sd3196,   16'sd13623,
      -16'sd13623, -16'sd3196,  16'sd16069,  -16'sd9102,
      16'sd6270,   -16'sd15137, 16'sd15137,  -16'sd6270,
      -16'sd6270,  16'sd15137,  -16'sd15137, 16'sd6270,
      16'sd3196,   -16'sd9102,  16'sd13623,  -16'sd16069,
      16'sd16069,  -16'sd13623, 16'sd9102,   -16'sd3196
   };

   typedef struct packed {
      logic mode;
      logic bank;
   } job_type;

   typedef struct packed {
      logic                       en;
      logic [BUF_AW-1:0]          addr;
      logic signed [SAMPLE_W-1:0] data;
   } buf_wr_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

endpackage

// ===== rtl/orthonormal_dct2_and_inverse_core.sv =====
// channel   ports                                     handshake
// request   req_sample, req_mode                      start high while busy low
// response  rsp_coefficient, rsp_out_index, rsp_last  rsp_valid, one cycle, no stall
//
// A sample is taken each cycle while its buffer bank is free; the eighth sample of a
// block queues a job and flips to the other bank. One shared multiplier does
// LENGTH*LENGTH = 64 multiply-accumulates per block, one per cycle, after the back
// end takes the job from the queue in its idle state.
// Each coefficient passes the read, product and accumulate stages and a registered
// rounding output; the words of a block come out in index order.
// Reset is synchronous; busy holds while both banks wait on the back end.
module orthonormal_dct2_and_inverse_core import dct_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_mode,
   output logic                       rsp_valid,
   output logic signed [COEF_W-1:0]   rsp_coefficient,
   output logic [IDX_W-1:0]           rsp_out_index,
   output logic                       rsp_last
);

   buf_wr_type  buf_wr;
   release_type rel;
   logic        push, pop, q_valid;
   job_type     push_job, q_job;

   dct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_sample (req_sample),
      .req_mode   (req_mode),
      .rel        (rel),
      .buf_wr     (buf_wr),
      .push       (push),
      .push_job   (push_job)
   );

   dct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_job    (q_job)
   );

   dct_back u_back (
      .clock           (clock),
      .reset           (reset),
      .buf_wr          (buf_wr),
      .q_valid         (q_valid),
      .q_job           (q_job),
      .pop             (pop),
      .rel             (rel),
      .rsp_valid       (rsp_valid),
      .rsp_coefficient (rsp_coefficient),
      .rsp_out_index   (rsp_out_index),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/dct_front.sv =====
module dct_front import dct_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_mode,
   input  release_type                rel,
   output buf_wr_type                 buf_wr,
   output logic                       push,
   output job_type                    push_job
);

   logic [IDX_W-1:0] fill_ff, fill_in;
   logic             bank_ff, bank_in;
   logic [1:0]       bank_busy_ff, bank_busy_in;
   logic             accept;
   logic             block_done;

   // a bank stays locked from its job push until the back end has read it out
   assign busy       = bank_busy_ff[bank_ff];
   assign accept     = start && !busy;
   assign block_done = (fill_ff == IDX_W'(LENGTH - 1));

   assign buf_wr.en   = accept;
   assign buf_wr.addr = {bank_ff, fill_ff};
   assign buf_wr.data = req_sample;

   assign push          = accept && block_done;
   assign push_job.mode = req_mode;
   assign push_job.bank = bank_ff;

   always_comb begin
      fill_in      = fill_ff;
      bank_in      = bank_ff;
      bank_busy_in = bank_busy_ff;
      if (rel.valid) begin
         bank_busy_in[rel.bank] = 1'b0;
      end
      if (accept) begin
         if (block_done) begin
            fill_in               = '0;
            bank_in               = !bank_ff;
            bank_busy_in[bank_ff] = 1'b1;
         end else begin
            fill_in = fill_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         bank_ff      <= 1'b0;
         bank_busy_ff <= '0;
      end else begin
         fill_ff      <= fill_in;
         bank_ff      <= bank_in;
         bank_busy_ff <= bank_busy_in;
      end
   end

endmodule

// ===== rtl/dct_queue.sv =====
module dct_queue import dct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    q_valid,
   output job_type q_job
);

   job_type    slot_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign q_valid = (count_ff != 2'd0);
   assign q_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !(pop && q_valid)) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop && q_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && q_valid) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

endmodule

// ===== rtl/dct_back.sv =====
module dct_back import dct_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  buf_wr_type               buf_wr,
   input  logic                     q_valid,
   input  job_type                  q_job,
   output logic                     pop,
   output release_type              rel,
   output logic                     rsp_valid,
   output logic signed [COEF_W-1:0] rsp_coefficient,
   output logic [IDX_W-1:0]         rsp_out_index,
   output logic                     rsp_last
);

   logic signed [SAMPLE_W-1:0] buf_mem [0:2*LENGTH-1];

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic             issue;
   logic [ROM_AW-1:0] rom_idx;

   // stage 1: sample read and weight lookup
   logic                       s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [IDX_W-1:0]           s1_j_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff, s1_weight_ff;
   // stage 2: product
   logic                       s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [IDX_W-1:0]           s2_j_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   // stage 3: accumulate
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       done_ff;
   logic [IDX_W-1:0]           done_j_ff;
   // output rounding
   logic signed [ACC_W-1:0]    rounded;
   logic signed [Q_W-1:0]      q_val;
   logic signed [COEF_W-1:0]   coef_in;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      pop      = 1'b0;
      issue    = 1'b0;
      rel      = '{valid: 1'b0, bank: job_ff.bank};
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               job_in   = q_job;
               i_in     = '0;
               j_in     = '0;
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            issue = 1'b1;
            i_in  = i_ff + IDX_W'(1);
            if (i_ff == IDX_W'(LENGTH - 1)) begin
               i_in = '0;
               j_in = j_ff + IDX_W'(1);
               if (j_ff == IDX_W'(LENGTH - 1)) begin
                  // last read of this bank goes out now
                  rel.valid = 1'b1;
                  state_in  = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // forward walks row j of the table, inverse walks column j
   assign rom_idx = (job_ff.mode == MODE_INV) ? {i_ff, j_ff} : {j_ff, i_ff};

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         buf_mem[buf_wr.addr] <= buf_wr.data;
      end
      s1_sample_ff <= buf_mem[{job_ff.bank, i_ff}];
      s1_weight_ff <= ROM[rom_idx];
      s1_first_ff  <= (i_ff == '0);
      s1_last_ff   <= (i_ff == IDX_W'(LENGTH - 1));
      s1_j_ff      <= j_ff;
      prod_ff      <= s1_weight_ff * s1_sample_ff;
      s2_first_ff  <= s1_first_ff;
      s2_last_ff   <= s1_last_ff;
      s2_j_ff      <= s1_j_ff;
      acc_ff       <= acc_in;
      done_j_ff    <= s2_j_ff;
      rsp_coefficient <= coef_in;
      rsp_out_index   <= done_j_ff;
      rsp_last        <= done_ff && (done_j_ff == IDX_W'(LENGTH - 1));
   end

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = (s2_first_ff ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
      end
   end

   assign rounded = acc_ff + ACC_W'(1 <<< (FRAC_SH - 1));
   assign q_val   = Q_W'(rounded >>> FRAC_SH);

   always_comb begin
      priority if (q_val > Q_W'(COEF_MAX)) begin
         coef_in = COEF_W'(COEF_MAX);
      end else if (q_val < Q_W'(COEF_MIN)) begin
         coef_in = COEF_W'(COEF_MIN);
      end else begin
         coef_in = q_val[COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         job_ff      <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         job_ff      <= job_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff && s2_last_ff;
         rsp_valid   <= done_ff;
      end
   end

endmodule

// ===== rtl/dct_chk.sv =====
module dct_chk import dct_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic [IDX_W-1:0]           rsp_out_index,
   input logic                       rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word right after reset");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_out_index == IDX_W'(LENGTH - 1))))
      else $error("last flag does not match final index");

   a_next_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> ##8
         (rsp_valid && rsp_out_index == $past(rsp_out_index, 8) + IDX_W'(1)))
      else $error("coefficient words out of sequence");

endmodule

bind orthonormal_dct2_and_inverse_core dct_chk u_dct_chk (.*);

// ===== verif/dct_result_checker.sv =====
`timescale 1ns / 100ps
module dct_result_checker import dct_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_mode,
   input  logic                       rsp_valid,
   input  logic signed [COEF_W-1:0]   rsp_coefficient,
   input  logic [IDX_W-1:0]           rsp_out_index,
   input  logic                       rsp_last,
   output int                         error_count,
   output int                         words_pending
);

   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;

   typedef struct packed {
      logic signed [COEF_W-1:0] value;
      logic [IDX_W-1:0]         index;
      logic                     last;
   } coef_word_type;

   int                         weight [LENGTH][LENGTH];
   logic signed [SAMPLE_W-1:0] held [LENGTH];
   int                         fill;
   coef_word_type              expected_coefs [$];

   // weights in Q1.15: scaled cosine, angle folded into the first quadrant
   initial begin
      longint unsigned scale, v, root, bitv, m, r, x, x2, term, mag;
      longint          csum, w;
      logic            neg;
      for (int k = 0; k < LENGTH; k++) begin
         v    = ((k == 0) ? (64'd1 << 60) : (64'd1 << 61)) / LENGTH;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v    = v - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv >>= 2;
         end
         scale = root;
         for (int n = 0; n < LENGTH; n++) begin
            m = longint'(k * (2 * n + 1)) % (4 * LENGTH);
            if (m <= LENGTH) begin
               r = m;
               neg = 1'b0;
            end else if (m <= 2 * LENGTH) begin
               r = 2 * LENGTH - m;
               neg = 1'b1;
            end else if (m <= 3 * LENGTH) begin
               r = m - 2 * LENGTH;
               neg = 1'b1;
            end else begin
               r = 4 * LENGTH - m;
               neg = 1'b0;
            end
            // Taylor series in Q30
            x    = (PI_Q30 * r) / (2 * LENGTH);
            x2   = (x * x) >> 30;
            term = ONE_Q30;
            csum = longint'(ONE_Q30);
            for (int i = 1; i <= 10; i++) begin
               term = ((term * x2) >> 30) / ((2 * i - 1) * (2 * i));
               if (i % 2 == 1) csum = csum - longint'(term);
               else csum = csum + longint'(term);
            end
            if (csum < 0) csum = 0;
            if (csum > longint'(ONE_Q30)) csum = longint'(ONE_Q30);
            mag = (scale * longint'(csum) + (64'd1 << 44)) >> 45;
            w   = neg ? -longint'(mag) : longint'(mag);
            if (w > 32767) w = 32767;
            if (w < -32768) w = -32768;
            weight[k][n] = int'(w);
         end
      end
   end

   always @(posedge clock) begin
      coef_word_type want;
      longint        acc, q;
      if (reset) begin
         fill = 0;
         foreach (held[i]) held[i] = '0;
         expected_coefs.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_coefs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word, expected none actual coefficient %0d index %0d",
                        $time, rsp_coefficient, rsp_out_index);
            end else begin
               want = expected_coefs.pop_front();
               if (rsp_coefficient !== want.value) begin
                  error_count++;
                  $display("%0t: coefficient mismatch, expected %0d actual %0d",
                           $time, want.value, rsp_coefficient);
               end
               if (rsp_out_index !== want.index) begin
                  error_count++;
                  $display("%0t: index mismatch, expected %0d actual %0d",
                           $time, want.index, rsp_out_index);
               end
               if (rsp_last !== want.last) begin
                  error_count++;
                  $display("%0t: last mismatch, expected %0b actual %0b",
                           $time, want.last, rsp_last);
               end
            end
         end
         if (start && !busy) begin
            held[fill] = req_sample;
            if (fill == LENGTH - 1) begin
               fill = 0;
               // block complete: mode of this word picks rows or columns
               for (int j = 0; j < LENGTH; j++) begin
                  acc = 0;
                  for (int i = 0; i < LENGTH; i++) begin
                     acc += longint'((req_mode == MODE_FWD) ? weight[j][i] : weight[i][j])
                            * longint'(held[i]);
                  end
                  q = (acc + 64'sd16384) >>> 15;
                  if (q > COEF_MAX) q = COEF_MAX;
                  if (q < COEF_MIN) q = COEF_MIN;
                  expected_coefs.push_back('{value: COEF_W'(q), index: IDX_W'(j),
                                             last: (j == LENGTH - 1)});
               end
            end else begin
               fill = fill + 1;
            end
         end
      end
      words_pending <= expected_coefs.size();
   end

endmodule

// ===== verif/orthonormal_dct2_and_inverse_core_tb.sv =====
`timescale 1ns / 100ps
module orthonormal_dct2_and_inverse_core_tb;
   import dct_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_BLOCKS = 32;
   localparam int PAUSE_BLOCK   = 14;
   localparam int TAIL_CYCLES   = 80;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_mode;
   logic                       rsp_valid;
   logic signed [COEF_W-1:0]   rsp_coefficient;
   logic [IDX_W-1:0]           rsp_out_index;
   logic                       rsp_last;
   int                         mismatches;
   int                         words_pending;
   int                         stall_cycles = 0;

   orthonormal_dct2_and_inverse_core u_top (.*);

   dct_result_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample      (req_sample),
      .req_mode        (req_mode),
      .rsp_valid       (rsp_valid),
      .rsp_coefficient (rsp_coefficient),
      .rsp_out_index   (rsp_out_index),
      .rsp_last        (rsp_last),
      .error_count     (mismatches),
      .words_pending   (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("orthonormal_dct2_and_inverse_core test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int kind);
      case (kind)
         1: return SAMPLE_W'(int'($urandom_range(255)) - 128);
         2: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic signed [SAMPLE_W-1:0] sample, input logic mode,
                            input logic may_idle);
      if (may_idle && $urandom_range(99) < 15) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_sample <= sample;
      req_mode   <= mode;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   initial begin
      int kind;
      reset      = 1'b1;
      start      = 1'b0;
      req_sample = '0;
      req_mode   = MODE_FWD;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full scale positive, forward; mode on the other words must be ignored
      for (int w = 0; w < LENGTH; w++)
         send_word(SAMPLE_MAX, (w == LENGTH - 1) ? MODE_FWD : MODE_INV, 1'b1);
      // full scale negative, inverse
      for (int w = 0; w < LENGTH; w++)
         send_word(SAMPLE_MIN, (w == LENGTH - 1) ? MODE_INV : MODE_FWD, 1'b1);
      // alternating extremes, forward
      for (int w = 0; w < LENGTH; w++)
         send_word((w % 2) ? SAMPLE_MIN : SAMPLE_MAX,
                   (w == LENGTH - 1) ? MODE_FWD : 1'($urandom_range(1)), 1'b1);

      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         kind = $urandom_range(5);
         for (int w = 0; w < LENGTH; w++)
            send_word(draw_sample(kind), 1'($urandom_range(1)), !(b >= 20 && b < 28));
         if (b == PAUSE_BLOCK) hold_until_drained();
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("orthonormal_dct2_and_inverse_core test passed");
      end else begin
         $display("orthonormal_dct2_and_inverse_core test failed");
      end
      $finish;
   end

endmodule

// ===== orthonormal_dct2_and_inverse_core.f =====
rtl/dct_pkg.sv
rtl/dct_front.sv
rtl/dct_queue.sv
rtl/dct_back.sv
rtl/orthonormal_dct2_and_inverse_core.sv
rtl/dct_chk.sv
verif/dct_result_checker.sv
verif/orthonormal_dct2_and_inverse_core_tb.sv
